### rtl/tea_pkg.sv
// ----------------------------------------------------------------------------
// TEA package
// Shared constants, types and the round mixing function of the TEA cipher.
// ----------------------------------------------------------------------------
package tea_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned TEA_ROUNDS = 32;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9E37_79B9;

  localparam logic KIND_ENCRYPT = 1'b0;
  localparam logic KIND_DECRYPT = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY3 = 2'd3;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    word_t k0;
    word_t k1;
    word_t k2;
    word_t k3;
  } key_t;

  typedef struct packed {
    logic  valid;
    logic  kind;
    word_t y;
    word_t z;
  } stage_t;

  function automatic word_t tea_mix(input word_t v, input word_t sum,
                                    input word_t kl, input word_t kr);
    tea_mix = ((v << 4) + kl) ^ (v + sum) ^ ((v >> 5) + kr);
  endfunction

endpackage

### rtl/tea_block_cipher_top.sv
// ----------------------------------------------------------------------------
// TEA block cipher top level
// Pipelined TEA encryption and decryption of 64-bit blocks with a 128-bit key.
// ----------------------------------------------------------------------------
// A new block may be taken on every clock cycle. Blocks are accepted only
// while in_tready is high. Each block passes through a chain of 2*ROUNDS
// cells, each performing one half of a Feistel round, and then the output
// register, by way of the skid entry when the output side stalls. in_tready
// is registered and drops only while the skid entry behind the output
// register is occupied. The key must only be written while no block is in
// flight.
module tea_block_cipher_top #(
  parameter int unsigned ROUNDS = tea_pkg::TEA_ROUNDS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [tea_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tea_pkg::WORD_W-1:0]      cfg_wdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [2*tea_pkg::WORD_W-1:0]    in_tdata,  // left_word, right_word
  input  logic                            in_tuser,  // kind
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [2*tea_pkg::WORD_W-1:0]    out_tdata  // left_result, right_result
);
  import tea_pkg::*;

  localparam int unsigned CELLS = 2 * ROUNDS;

  key_t   key_r;
  stage_t chain [0:CELLS];
  logic   advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_KEY0: key_r.k0 <= cfg_wdata;
        CFG_KEY1: key_r.k1 <= cfg_wdata;
        CFG_KEY2: key_r.k2 <= cfg_wdata;
        CFG_KEY3: key_r.k3 <= cfg_wdata;
        default:  key_r    <= key_r;
      endcase
    end
  end

  assign in_tready      = advance;
  assign chain[0].valid = in_tvalid;
  assign chain[0].kind  = in_tuser;
  assign chain[0].y     = in_tdata[WORD_W-1:0];
  assign chain[0].z     = in_tdata[2*WORD_W-1:WORD_W];

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    tea_cell #(
      .ROUNDS    (ROUNDS),
      .ROUND_IDX (i / 2),
      .HALF      (1'(i % 2))
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (advance),
      .key   (key_r),
      .d_in  (chain[i]),
      .d_out (chain[i+1])
    );
  end

  tea_out_skid u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .d_in      (chain[CELLS]),
    .advance   (advance),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule

### rtl/tea_cell.sv
// ----------------------------------------------------------------------------
// TEA half-round cell
// Applies one half of a Feistel round, in either direction, and registers it.
// ----------------------------------------------------------------------------
module tea_cell #(
  parameter int unsigned ROUNDS    = tea_pkg::TEA_ROUNDS,
  parameter int unsigned ROUND_IDX = 0,
  parameter bit          HALF      = 1'b0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  tea_pkg::key_t   key,
  input  tea_pkg::stage_t d_in,
  output tea_pkg::stage_t d_out
);
  import tea_pkg::*;

  localparam logic [63:0] ENC_PROD = 64'(TEA_DELTA) * 64'(ROUND_IDX + 1);
  localparam logic [63:0] DEC_PROD = 64'(TEA_DELTA) * 64'(ROUNDS - ROUND_IDX);
  localparam word_t       SUM_ENC  = ENC_PROD[WORD_W-1:0];
  localparam word_t       SUM_DEC  = DEC_PROD[WORD_W-1:0];

  logic   dec;
  logic   upd_y;
  word_t  sum;
  word_t  mixed;
  stage_t stage_nxt;
  stage_t stage_r;

  always_comb begin
    dec   = (d_in.kind == KIND_DECRYPT);
    upd_y = HALF ^ ~dec;
    sum   = dec ? SUM_DEC : SUM_ENC;
    if (upd_y) begin
      mixed = tea_mix(d_in.z, sum, key.k0, key.k1);
    end else begin
      mixed = tea_mix(d_in.y, sum, key.k2, key.k3);
    end
    stage_nxt = d_in;
    if (upd_y) begin
      stage_nxt.y = dec ? (d_in.y - mixed) : (d_in.y + mixed);
    end else begin
      stage_nxt.z = dec ? (d_in.z - mixed) : (d_in.z + mixed);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else if (en) begin
      stage_r.valid <= stage_nxt.valid;
    end
    if (en) begin
      stage_r.kind <= stage_nxt.kind;
      stage_r.y    <= stage_nxt.y;
      stage_r.z    <= stage_nxt.z;
    end
  end

  assign d_out = stage_r;

endmodule

### rtl/tea_out_skid.sv
// ----------------------------------------------------------------------------
// TEA output skid stage
// Output register plus one skid entry, so the cell chain stalls on a register.
// ----------------------------------------------------------------------------
module tea_out_skid (
  input  logic                       clk,
  input  logic                       rst_n,
  input  tea_pkg::stage_t            d_in,
  output logic                       advance,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [2*tea_pkg::WORD_W-1:0] out_data
);
  import tea_pkg::*;

  logic                  out_valid_r;
  logic                  out_valid_nxt;
  logic [2*WORD_W-1:0]   out_data_r;
  logic [2*WORD_W-1:0]   out_data_nxt;
  logic                  skid_valid_r;
  logic                  skid_valid_nxt;
  logic [2*WORD_W-1:0]   skid_data_r;
  logic [2*WORD_W-1:0]   skid_data_nxt;
  logic                  out_free;

  always_comb begin
    advance        = ~skid_valid_r;
    out_free       = ~out_valid_r | out_ready;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (out_ready) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (d_in.valid) begin
      if (out_free) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = {d_in.z, d_in.y};
      end else begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = {d_in.z, d_in.y};
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
